>>> hdl/csmv_pkg.sv
// shared types, sizes and codes for the csr sparse matrix vector engine
package csmv_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_NONZEROS = 4096;
    localparam int MAX_COLS     = 1024;

    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;
    localparam int VAL_W  = 32;
    localparam int DOT_W  = 64;
    localparam int CFG_W  = 11;
    localparam int DATA_W = 32;
    localparam int CFG_AW = 3;

    localparam int RS_DEPTH = MAX_ROWS + 1;
    localparam int RS_AW    = $clog2(RS_DEPTH);
    localparam int NZ_AW    = $clog2(MAX_NONZEROS);
    localparam int VEC_AW   = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_NONZEROS + 1);
    localparam int NZ_W     = COL_W + VAL_W;

    // register index taken from paddr[2]
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR     = 2'd0,
        ACT_INSERT    = 2'd1,
        ACT_VEC_WRITE = 2'd2,
        ACT_DOT       = 2'd3
    } csmv_action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } csmv_status_t;

    typedef struct packed {
        csmv_action_t             action;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } csmv_cmd_t;

    typedef struct packed {
        csmv_status_t             status;
        logic signed [DOT_W-1:0]  dot;
    } csmv_rsp_t;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CLEAR   = 6'b000010,
        S_INSERT  = 6'b000100,
        S_DOT_LO  = 6'b001000,
        S_DOT_HI  = 6'b010000,
        S_DOT_RUN = 6'b100000
    } csmv_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } csmv_mac_ctrl_t;

endpackage

>>> hdl/csr_sparse_matrix_vector_engine_top.sv
// csr sparse matrix store with vector store and row dot product engine
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------
//  command  | start, busy (start & !busy)  | cmd    : csmv_cmd_t
//  result   | done, one cycle, no stall    | result : csmv_rsp_t
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
//  vector write and any refused item: result the cycle after start, busy stays low
//  insert: row start entries row + 1 up to rows_used are each incremented, one row start entry a cycle
//  dot: the two row start entries of the row are read, then its nonzeros pass
//    through the shared multiply accumulate unit, one nonzero a cycle
//  clear: zeroes every row start entry and the nonzero count; after reset a clearing pass keeps busy high
//  config writes are taken at any time; the receiver cannot stall results
module csr_sparse_matrix_vector_engine_top
    import csmv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  csmv_cmd_t          cmd,
    output logic               done,
    output csmv_rsp_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    csmv_state_t state_reg, state_next;
    csmv_cmd_t   cmd_reg;

    logic [CFG_W-1:0]  num_rows_reg, num_cols_reg;
    logic [CFG_W-1:0]  rows_used, cols_used;
    logic              cfg_wr;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [RS_AW-1:0]  idx_reg, idx_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [RS_AW-1:0]  wb_addr_reg, wb_addr_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic              p1_valid_reg, p1_valid_next;
    logic              p2_valid_reg;
    logic              clear_cmd_reg, clear_cmd_next;
    logic              done_reg, done_next;
    csmv_rsp_t         result_reg, result_next;
    logic signed [VAL_W-1:0] a_reg;

    logic              accept, row_bad, col_bad;

    // row start memory
    logic [CNT_W-1:0]  rs_mem [0:RS_DEPTH-1];
    logic              rs_we;
    logic [RS_AW-1:0]  rs_waddr, rs_raddr;
    logic [CNT_W-1:0]  rs_wdata, rs_rdata_reg;

    // nonzero memory: column index over value
    logic [NZ_W-1:0]   nz_mem [0:MAX_NONZEROS-1];
    logic              nz_we;
    logic [NZ_AW-1:0]  nz_waddr, nz_raddr;
    logic [NZ_W-1:0]   nz_wdata, nz_rdata_reg;

    // vector memory
    logic [VAL_W-1:0]  vec_mem [0:MAX_COLS-1];
    logic              vec_we;
    logic [VEC_AW-1:0] vec_waddr, vec_raddr;
    logic [VAL_W-1:0]  vec_wdata, vec_rdata_reg;

    csmv_mac_ctrl_t           mac_ctrl;
    logic                     mac_busy;
    logic signed [DOT_W-1:0]  mac_acc;

    // config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_W'(MAX_ROWS);
            num_cols_reg <= CFG_W'(MAX_COLS);
        end
        else if (cfg_wr)
        begin
            if (paddr[CFG_AW-1:2] == REG_NUM_COLS)
            begin
                num_cols_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                num_rows_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[CFG_AW-1:2] == REG_NUM_COLS) ? DATA_W'(num_cols_reg)
                                                        : DATA_W'(num_rows_reg);

    always_comb
    begin
        priority if (num_rows_reg == '0)
            rows_used = CFG_W'(1);
        else if (num_rows_reg > CFG_W'(MAX_ROWS))
            rows_used = CFG_W'(MAX_ROWS);
        else
            rows_used = num_rows_reg;
        priority if (num_cols_reg == '0)
            cols_used = CFG_W'(1);
        else if (num_cols_reg > CFG_W'(MAX_COLS))
            cols_used = CFG_W'(MAX_COLS);
        else
            cols_used = num_cols_reg;
    end

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign row_bad = CFG_W'(cmd.row) >= rows_used;
    assign col_bad = CFG_W'(cmd.col) >= cols_used;

    // dot pipeline: nonzero read, then vector read, then the shared unit
    assign vec_raddr      = nz_rdata_reg[VAL_W +: COL_W];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        p1_valid_next  = 1'b0;
        count_next     = count_reg;
        clear_cmd_next = clear_cmd_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        rs_we          = 1'b0;
        rs_waddr       = idx_reg;
        rs_wdata       = '0;
        rs_raddr       = idx_reg;
        nz_we          = 1'b0;
        nz_waddr       = count_reg[NZ_AW-1:0];
        nz_wdata       = {cmd.col, cmd.value};
        nz_raddr       = ptr_reg[NZ_AW-1:0];
        vec_we         = 1'b0;
        vec_waddr      = cmd.col;
        vec_wdata      = cmd.value;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.valid = p2_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.action)
                        ACT_CLEAR:
                        begin
                            count_next     = '0;
                            idx_next       = '0;
                            clear_cmd_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        ACT_INSERT:
                        begin
                            priority if (row_bad || col_bad)
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: STATUS_RANGE, dot: '0};
                            end
                            else if (count_reg == CNT_W'(MAX_NONZEROS))
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: STATUS_FULL, dot: '0};
                            end
                            else
                            begin
                                nz_we      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                idx_next   = RS_AW'(cmd.row) + RS_AW'(1);
                                state_next = S_INSERT;
                            end
                        end
                        ACT_VEC_WRITE:
                        begin
                            done_next = 1'b1;
                            if (col_bad)
                            begin
                                result_next = '{status: STATUS_RANGE, dot: '0};
                            end
                            else
                            begin
                                vec_we      = 1'b1;
                                result_next = '{status: STATUS_OK, dot: '0};
                            end
                        end
                        ACT_DOT:
                        begin
                            if (row_bad)
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: STATUS_RANGE, dot: '0};
                            end
                            else
                            begin
                                rs_raddr       = RS_AW'(cmd.row);
                                mac_ctrl.clear = 1'b1;
                                state_next     = S_DOT_LO;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                rs_we = 1'b1;
                if (idx_reg == RS_AW'(RS_DEPTH - 1))
                begin
                    state_next     = S_IDLE;
                    clear_cmd_next = 1'b0;
                    if (clear_cmd_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: STATUS_OK, dot: '0};
                    end
                end
                else
                begin
                    idx_next = idx_reg + RS_AW'(1);
                end
            end
            S_INSERT:
            begin
                // read entry k while entry k-1 is written back plus one
                rs_we    = wb_valid_reg;
                rs_waddr = wb_addr_reg;
                rs_wdata = rs_rdata_reg + CNT_W'(1);
                if (idx_reg <= RS_AW'(rows_used))
                begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = idx_reg;
                    idx_next      = idx_reg + RS_AW'(1);
                end
                else if (!wb_valid_reg)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{status: STATUS_OK, dot: '0};
                end
            end
            S_DOT_LO:
            begin
                ptr_next   = rs_rdata_reg;
                rs_raddr   = RS_AW'(cmd_reg.row) + RS_AW'(1);
                state_next = S_DOT_HI;
            end
            S_DOT_HI:
            begin
                end_next   = (rs_rdata_reg > count_reg) ? count_reg : rs_rdata_reg;
                state_next = S_DOT_RUN;
            end
            S_DOT_RUN:
            begin
                if (ptr_reg < end_reg)
                begin
                    p1_valid_next = 1'b1;
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else if (!p1_valid_reg && !p2_valid_reg && !mac_busy)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{status: STATUS_OK, dot: mac_acc};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            clear_cmd_reg <= 1'b0;
            count_reg     <= '0;
            wb_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            clear_cmd_reg <= clear_cmd_next;
            count_reg     <= count_next;
            wb_valid_reg  <= wb_valid_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p1_valid_reg;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        wb_addr_reg <= wb_addr_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        result_reg  <= result_next;
        a_reg       <= nz_rdata_reg[VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
        begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        rs_rdata_reg <= rs_mem[rs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nz_we)
        begin
            nz_mem[nz_waddr] <= nz_wdata;
        end
        nz_rdata_reg <= nz_mem[nz_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        vec_rdata_reg <= vec_mem[vec_raddr];
    end

    csmv_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .mat_val (a_reg),
        .vec_val (vec_rdata_reg),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hdl/csmv_mac.sv
// shared multiply and saturating accumulate unit for the row dot product
module csmv_mac
    import csmv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  csmv_mac_ctrl_t           ctrl,
    input  logic signed [VAL_W-1:0]  mat_val,
    input  logic signed [VAL_W-1:0]  vec_val,
    output logic                     busy,
    output logic signed [DOT_W-1:0]  acc
);

    logic                     prod_valid_reg;
    logic signed [DOT_W-1:0]  prod_reg;
    logic signed [DOT_W-1:0]  prod_next;
    logic signed [DOT_W-1:0]  acc_reg;
    logic signed [DOT_W-1:0]  acc_next;
    logic [DOT_W:0]           sum;

    assign prod_next = DOT_W'(mat_val) * DOT_W'(vec_val);
    assign sum       = {acc_reg[DOT_W-1], acc_reg} + {prod_reg[DOT_W-1], prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        priority if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            // clamp when the extra sign bit disagrees with the top bit
            if (sum[DOT_W] != sum[DOT_W-1])
            begin
                acc_next = sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
            end
            else
            begin
                acc_next = sum[DOT_W-1:0];
            end
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign busy = prod_valid_reg;
    assign acc  = acc_reg;

endmodule

>>> hdl/csmv_checker.sv
// port level checks for the csr sparse matrix vector engine, bound to the top level
module csmv_checker
    import csmv_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input csmv_rsp_t result
);

    // every accepted transaction either answers at once or holds busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transaction neither answered nor went busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != STATUS_OK |-> result.dot == '0)
        else $error("refused transaction carries a nonzero dot");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

endmodule

bind csr_sparse_matrix_vector_engine_top csmv_checker u_csmv_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
